// File: rtl/hmcs_pkg.sv
// ----------------------------------------------------------------------------
// hmcs_pkg
// Widths, constants and the heap entry type shared by the cube-sum merge.
// ----------------------------------------------------------------------------
package hmcs_pkg;

	localparam int VAL_W  = 10;
	localparam int IDX_W  = 3;
	localparam int CNT_W  = 4;
	localparam int NC_W   = 4;
	localparam int SQ_W   = 2 * VAL_W;
	localparam int CUBE_W = 3 * VAL_W;
	localparam int SUM_W  = CUBE_W + 1;
	localparam int KEY_W  = 32;
	localparam int EMIT_W = 7;

	// Exhausted row: sorts above every real sum.
	localparam logic [KEY_W-1:0] KEY_EXHAUSTED = {KEY_W{1'b1}};

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] row;
		logic [NC_W-1:0]  nc;
	} heap_ent_t;

endpackage

// File: rtl/hmcs_in_if.sv
// ----------------------------------------------------------------------------
// hmcs_in_if
// Value channel: one list value per transaction, last starts the merge.
// ----------------------------------------------------------------------------
interface hmcs_in_if
	import hmcs_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] value;
	logic             last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

// File: rtl/hmcs_out_if.sv
// ----------------------------------------------------------------------------
// hmcs_out_if
// Result channel: one cube sum with its row and column per transaction.
// ----------------------------------------------------------------------------
interface hmcs_out_if
	import hmcs_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] sum;
	logic [IDX_W-1:0] row_index;
	logic [IDX_W-1:0] col_index;
	logic             end_of_run;

	modport source (output valid, output sum, output row_index, output col_index,
		output end_of_run, input ready);
	modport sink   (input valid, input sum, input row_index, input col_index,
		input end_of_run, output ready);
endinterface

// File: rtl/heap_merge_cube_sums.sv
// ----------------------------------------------------------------------------
// heap_merge_cube_sums
// K-way merge of the sums a[r]^3 + a[c]^3 through a min-heap held in memory.
// ----------------------------------------------------------------------------
// Usage:
//   values: one list value per transaction (ascending order expected). Up to
//     MAX_VALUES are stored; later ones are dropped. A transaction with last
//     set closes the list and starts the merge; ready stays low until every
//     result of the merge has been produced.
//   sums: k*k transactions per merge, smallest sum first, each with its row
//     and column; end_of_run marks the final one.
// Sequence:
//   Loading accepts one value per cycle while ready is high. Building the heap
//   addresses the value store for each loaded value, then waits for the store
//   read and the cube pipeline (square, cube, add) before writing its entry.
//   Each result is emitted, then the next sum of its row is computed (skipped
//   when the row is exhausted), then sift-down reads the children and then
//   compares and writes back at each heap level; at a leaf the entry is parked.
// Reset: clears the load count and the merge control; the stores keep junk
//   that is never read before it is written.
// Stall: a held result waits in the output register; the merge freezes at
//   the next emit until the receiver takes it.
// ----------------------------------------------------------------------------
module heap_merge_cube_sums
	import hmcs_pkg::*;
#(
	parameter int MAX_VALUES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	hmcs_in_if.sink    values,
	hmcs_out_if.source sums
);

	localparam logic [2:0] S_LOAD      = 3'd0;
	localparam logic [2:0] S_INIT      = 3'd1;
	localparam logic [2:0] S_INIT_WAIT = 3'd2;
	localparam logic [2:0] S_EMIT      = 3'd3;
	localparam logic [2:0] S_NEXT_WAIT = 3'd4;
	localparam logic [2:0] S_SIFT_RD   = 3'd5;
	localparam logic [2:0] S_SIFT_CMP  = 3'd6;

	localparam logic [2:0]       CALC_LAT = 3'd4;
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_VALUES);

	// Stores
	logic [VAL_W-1:0] vmem [MAX_VALUES];
	heap_ent_t        hmem [MAX_VALUES];

	// Control
	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [EMIT_W-1:0] total_q;
	logic [EMIT_W-1:0] emit_cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  pos_q;
	logic [2:0]        wait_q;
	logic              out_valid_q;

	// Payload
	logic [IDX_W-1:0] raddr_a_q, raddr_b_q;
	heap_ent_t        root_q, hold_q;
	logic [SUM_W-1:0] sum_q;
	logic [IDX_W-1:0] row_q, col_q;
	logic             end_q;

	// Cube pipeline
	logic [VAL_W-1:0]  va_s1, vb_s1, va_s2, vb_s2;
	logic [SQ_W-1:0]   sqa_s2, sqb_s2;
	logic [CUBE_W-1:0] cua_s3, cub_s3;
	logic [SUM_W-1:0]  sum_s4;

	// Sift read data
	heap_ent_t rd_l_s1, rd_r_s1;

	logic [IDX_W+1:0]  left_w, right_w;
	logic              l_in, r_in;
	heap_ent_t         best;
	logic              moved;
	logic              out_free, emit_fire, last_emit, calc_done;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	heap_ent_t         wr_data;
	logic              in_fire, store_ok;
	logic [CNT_W-1:0]  cnt_next;
	logic [2*CNT_W-1:0] k_sq;

	assign values.ready = (state_q == S_LOAD);
	assign in_fire      = values.valid && values.ready;
	assign store_ok     = (cnt_q < MAX_CNT);
	assign cnt_next     = store_ok ? cnt_q + 1'b1 : cnt_q;
	assign k_sq         = cnt_next * cnt_next;

	assign sums.valid      = out_valid_q;
	assign sums.sum        = sum_q;
	assign sums.row_index  = row_q;
	assign sums.col_index  = col_q;
	assign sums.end_of_run = end_q;

	always_comb begin
		left_w    = {1'b0, pos_q, 1'b1};
		right_w   = left_w + 1'b1;
		l_in      = left_w < {1'b0, cnt_q};
		r_in      = right_w < {1'b0, cnt_q};
		best      = hold_q;
		moved     = 1'b0;
		if (l_in && (rd_l_s1.key < hold_q.key)) begin
			best  = rd_l_s1;
			moved = 1'b1;
		end
		if (r_in && (rd_r_s1.key < best.key)) begin
			best  = rd_r_s1;
			moved = 1'b1;
		end
		out_free  = !out_valid_q || sums.ready;
		emit_fire = (state_q == S_EMIT) && out_free;
		last_emit = (emit_cnt_q + 1'b1) == total_q;
		calc_done = (wait_q == '0);

		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = best;
		case (state_q)
			S_INIT_WAIT: begin
				wr_en   = calc_done;
				wr_addr = idx_q;
				wr_data = '{key: {1'b0, sum_s4}, row: idx_q, nc: NC_W'(1)};
			end
			S_SIFT_RD: begin
				wr_en   = !l_in;
				wr_data = hold_q;
			end
			S_SIFT_CMP: begin
				wr_en = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			cnt_q       <= '0;
			total_q     <= '0;
			emit_cnt_q  <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			wait_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (sums.ready) begin
				out_valid_q <= 1'b0;
			end
			if (wait_q != '0) begin
				wait_q <= wait_q - 1'b1;
			end
			case (state_q)
				S_LOAD: begin
					if (in_fire) begin
						cnt_q <= cnt_next;
						if (values.last) begin
							total_q <= k_sq[EMIT_W-1:0];
							idx_q   <= '0;
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					wait_q  <= CALC_LAT;
					state_q <= S_INIT_WAIT;
				end
				S_INIT_WAIT: begin
					if (calc_done) begin
						idx_q <= idx_q + 1'b1;
						if ({1'b0, idx_q} + 1'b1 == cnt_q) begin
							emit_cnt_q <= '0;
							state_q    <= S_EMIT;
						end else begin
							state_q <= S_INIT;
						end
					end
				end
				S_EMIT: begin
					if (emit_fire) begin
						pos_q <= '0;
						if (last_emit) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end else begin
							emit_cnt_q <= emit_cnt_q + 1'b1;
							if (root_q.nc < cnt_q) begin
								wait_q  <= CALC_LAT;
								state_q <= S_NEXT_WAIT;
							end else begin
								state_q <= S_SIFT_RD;
							end
						end
					end
				end
				S_NEXT_WAIT: begin
					if (calc_done) begin
						state_q <= S_SIFT_RD;
					end
				end
				S_SIFT_RD: begin
					state_q <= l_in ? S_SIFT_CMP : S_EMIT;
				end
				S_SIFT_CMP: begin
					if (moved) begin
						// advance the hole into the chosen child
						pos_q   <= (r_in && (rd_r_s1.key < best.key || best == rd_r_s1)
							&& !(best == rd_l_s1 && rd_l_s1 != rd_r_s1))
							? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
						state_q <= S_SIFT_RD;
					end else begin
						state_q <= S_EMIT;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Payload registers and read addresses
	always_ff @(posedge clk) begin
		if (state_q == S_INIT) begin
			raddr_a_q <= idx_q;
			raddr_b_q <= '0;
		end else if (emit_fire) begin
			raddr_a_q <= root_q.row;
			raddr_b_q <= root_q.nc[IDX_W-1:0];
		end
		if (emit_fire) begin
			sum_q  <= root_q.key[SUM_W-1:0];
			row_q  <= root_q.row;
			col_q  <= IDX_W'(root_q.nc - 1'b1);
			end_q  <= last_emit;
			hold_q <= '{key: KEY_EXHAUSTED, row: root_q.row, nc: root_q.nc};
		end else if (state_q == S_NEXT_WAIT && calc_done) begin
			hold_q <= '{key: {1'b0, sum_s4}, row: hold_q.row, nc: hold_q.nc + 1'b1};
		end
		if (wr_en && wr_addr == '0) begin
			root_q <= wr_data;
		end
	end

	// Value store: write on load, two registered read ports
	always_ff @(posedge clk) begin
		if (in_fire && store_ok) begin
			vmem[cnt_q[IDX_W-1:0]] <= values.value;
		end
		va_s1 <= vmem[raddr_a_q];
		vb_s1 <= vmem[raddr_b_q];
	end

	// Heap store: entries below the root, two registered child reads
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr != '0) begin
			hmem[wr_addr] <= wr_data;
		end
		rd_l_s1 <= hmem[left_w[IDX_W-1:0]];
		rd_r_s1 <= hmem[right_w[IDX_W-1:0]];
	end

	// Cube pipeline: square, cube, add
	always_ff @(posedge clk) begin
		sqa_s2 <= va_s1 * va_s1;
		sqb_s2 <= vb_s1 * vb_s1;
		va_s2  <= va_s1;
		vb_s2  <= vb_s1;
		cua_s3 <= sqa_s2 * va_s2;
		cub_s3 <= sqb_s2 * vb_s2;
		sum_s4 <= {1'b0, cua_s3} + {1'b0, cub_s3};
	end

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD && state_q != S_INIT && state_q != S_INIT_WAIT)
		|-> (emit_cnt_q < total_q))
		else $error("emit count ran past k*k");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> (cnt_q != '0 && cnt_q <= MAX_CNT))
		else $error("merge running with bad value count");

	a_root_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (root_q.key != KEY_EXHAUSTED))
		else $error("exhausted row reached the root before the end");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SIFT_CMP) |-> ({1'b0, pos_q} < cnt_q && l_in))
		else $error("sift position outside the heap");

	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && last_emit) |=> (state_q == S_LOAD && cnt_q == '0))
		else $error("merge did not return to loading after its last result");

endmodule

// File: test/cube_sum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_sum_checker
// Watches the value and sum channels of heap_merge_cube_sums, runs its own
// min-heap merge of cube sums on every accepted list and compares each sum
// transaction, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module cube_sum_checker
	import hmcs_pkg::*;
#(
	parameter int MAX_VALUES = 8
) (
	input  logic clk,
	input  logic arst_n,
	hmcs_in_if   values,
	hmcs_out_if  sums,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             eor;
	} cube_sum_t;

	cube_sum_t        sum_q[$];
	logic [VAL_W-1:0] list_vals [MAX_VALUES];
	int               list_len;
	int               err_cnt;

	function automatic logic [KEY_W-1:0] cube_of(logic [VAL_W-1:0] v);
		logic [KEY_W-1:0] x;
		x = v;
		return x * x * x;
	endfunction

	// Run the whole merge for the list held so far and queue every sum.
	task automatic merge_list();
		heap_ent_t heap [MAX_VALUES];
		heap_ent_t tmp;
		cube_sum_t res;
		int        k;
		int        total;
		int        pos;
		int        best;
		bit        settled;
		k = list_len;
		total = k * k;
		for (int i = 0; i < k; i++) begin
			heap[i].key = cube_of(list_vals[i]) + cube_of(list_vals[0]);
			heap[i].row = IDX_W'(i);
			heap[i].nc  = NC_W'(1);
		end
		for (int n = 0; n < total; n++) begin
			res.sum = heap[0].key[SUM_W-1:0];
			res.row = heap[0].row;
			res.col = IDX_W'(heap[0].nc - NC_W'(1));
			res.eor = (n == total - 1);
			sum_q.push_back(res);
			if (int'(heap[0].nc) < k) begin
				heap[0].key = cube_of(list_vals[heap[0].row])
					+ cube_of(list_vals[heap[0].nc[IDX_W-1:0]]);
				heap[0].nc = heap[0].nc + NC_W'(1);
			end else begin
				heap[0].key = KEY_EXHAUSTED;
			end
			// sift down: strict less-than, left child first
			pos = 0;
			settled = 0;
			while (!settled) begin
				best = pos;
				if (2 * pos + 1 < k && heap[2 * pos + 1].key < heap[pos].key)
					best = 2 * pos + 1;
				if (2 * pos + 2 < k && heap[2 * pos + 2].key < heap[best].key)
					best = 2 * pos + 2;
				if (best == pos) begin
					settled = 1;
				end else begin
					tmp = heap[pos];
					heap[pos] = heap[best];
					heap[best] = tmp;
					pos = best;
				end
			end
		end
		list_len = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cube_sum_t want;
		if (!arst_n) begin
			list_len = 0;
			err_cnt = 0;
			sum_q.delete();
		end else begin
			if (values.valid && values.ready) begin
				// drop values past a full store, still honor last
				if (list_len < MAX_VALUES) begin
					list_vals[list_len] = values.value;
					list_len++;
				end
				if (values.last)
					merge_list();
			end
			if (sums.valid && sums.ready) begin
				if (sum_q.size() == 0) begin
					$error("unexpected sum transaction: sum %0d row %0d col %0d",
						sums.sum, sums.row_index, sums.col_index);
					err_cnt++;
				end else begin
					want = sum_q.pop_front();
					if (sums.sum !== want.sum) begin
						$error("sum: expected %0d, got %0d", want.sum, sums.sum);
						err_cnt++;
					end
					if (sums.row_index !== want.row) begin
						$error("row_index: expected %0d, got %0d", want.row, sums.row_index);
						err_cnt++;
					end
					if (sums.col_index !== want.col) begin
						$error("col_index: expected %0d, got %0d", want.col, sums.col_index);
						err_cnt++;
					end
					if (sums.end_of_run !== want.eor) begin
						$error("end_of_run: expected %0d, got %0d", want.eor,
							sums.end_of_run);
						err_cnt++;
					end
				end
			end
		end
		errors <= err_cnt;
		pending <= sum_q.size();
	end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for heap_merge_cube_sums: sends directed and random value lists
// with random idling on both channels and lets cube_sum_checker predict and
// compare every merged cube sum.
// ----------------------------------------------------------------------------
module tb_top
	import hmcs_pkg::*;
;

	localparam int MAX_VALUES  = 8;
	localparam int RAND_ITEMS  = 400;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   cycles;
	int   send_idle;
	int   recv_idle;
	int   sent;

	logic [VAL_W-1:0] list_q[$];

	hmcs_in_if  values_ch ();
	hmcs_out_if sums_ch ();

	heap_merge_cube_sums #(
		.MAX_VALUES(MAX_VALUES)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.values (values_ch),
		.sums   (sums_ch)
	);

	cube_sum_checker #(
		.MAX_VALUES(MAX_VALUES)
	) sum_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.values  (values_ch),
		.sums    (sums_ch),
		.errors  (errors),
		.pending (pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		sums_ch.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Send list_q as one list, last on its final value, then empty it.
	task automatic send_list();
		for (int i = 0; i < list_q.size(); i++) begin
			while ($urandom_range(99) < send_idle) begin
				values_ch.valid <= 1'b0;
				@(posedge clk);
			end
			values_ch.valid <= 1'b1;
			values_ch.value <= list_q[i];
			values_ch.last  <= (i == list_q.size() - 1);
			do @(posedge clk); while (!values_ch.ready);
			sent++;
			// sender idles 17 of 100 and receiver 65, then the reverse, then nobody
			if (sent < RAND_ITEMS / 3) begin
				send_idle = 17;
				recv_idle = 65;
			end else if (sent < 2 * RAND_ITEMS / 3) begin
				send_idle = 65;
				recv_idle = 17;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
		end
		list_q.delete();
	endtask

	initial begin
		int               len;
		int               hi;
		int               j;
		logic [VAL_W-1:0] v;
		clk = 1'b0;
		arst_n = 1'b0;
		cycles = 0;
		sent = 0;
		send_idle = 17;
		recv_idle = 65;
		values_ch.valid = 1'b0;
		values_ch.value = '0;
		values_ch.last  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-value lists at both extremes, then both extremes together
		list_q = '{10'd0};
		send_list();
		list_q = '{10'd1023};
		send_list();
		list_q = '{10'd0, 10'd1023};
		send_list();
		// unsorted: heap used as loaded
		list_q = '{10'd5, 10'd3, 10'd9};
		send_list();
		// equal values tie on every key
		list_q = '{10'd7, 10'd7, 10'd7};
		send_list();
		// store full: two values dropped, the last one still starts the merge
		list_q = '{10'd1014, 10'd1016, 10'd1017, 10'd1018, 10'd1019, 10'd1020,
			10'd1021, 10'd1023, 10'd1, 10'd2};
		send_list();

		while (sent < RAND_ITEMS) begin
			if ($urandom_range(9) == 0)
				len = $urandom_range(MAX_VALUES + 3, MAX_VALUES + 1);
			else
				len = $urandom_range(MAX_VALUES, 1);
			hi = ($urandom_range(3) == 0) ? 15 : 1023;
			for (int i = 0; i < len; i++) begin
				v = VAL_W'($urandom_range(hi));
				list_q.push_back(v);
			end
			// most lists ascending; the rest stay unsorted
			if ($urandom_range(4) != 0) begin
				for (int i = 1; i < len; i++) begin
					v = list_q[i];
					j = i - 1;
					while (j >= 0 && list_q[j] > v) begin
						list_q[j + 1] = list_q[j];
						j--;
					end
					list_q[j + 1] = v;
				end
			end
			send_list();
		end
		values_ch.valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
rtl/hmcs_pkg.sv
rtl/hmcs_in_if.sv
rtl/hmcs_out_if.sv
rtl/heap_merge_cube_sums.sv
test/cube_sum_checker.sv
test/tb_top.sv
